### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge, disabled in reset.
`define ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Implication with the consequent in the following cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants, types and helpers of the integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sitoa_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	// BCD correction of the shift-add-3 step
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;

	// Decimal digits needed for magnitudes up to 2^(bits-1).
	// 30103/100000 approximates log10(2) closely enough for bits <= 64.
	function automatic int digit_count(input int bits);
		return ((bits - 1) * 30103) / 100000 + 1;
	endfunction

	// Load request from the sequencer to the character emitter
	typedef struct packed {
		logic load;
		logic negative;
	} emit_ctl_t;

endpackage

`default_nettype wire

### rtl/sitoa_dabble.sv
// ----------------------------------------------------------------------------
// sitoa_dabble
// Binary to BCD converter: one shift-add-3 step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sitoa_dabble #(
	parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [VALUE_BITS-1:0]       mag,
	output logic                             done,
	output logic [sitoa_pkg::digit_count(VALUE_BITS)*4-1:0] bcd
);

	localparam int DIGITS = sitoa_pkg::digit_count(VALUE_BITS);
	localparam int BCD_W  = DIGITS * 4;
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= sitoa_pkg::BCD_ADJ_MIN)
				adj[4*i +: 4] = bcd_q[4*i +: 4] + sitoa_pkg::BCD_ADJ;
			else
				adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse after the final shift
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(VALUE_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			{bcd_q, bin_q} <= {adj[BCD_W-2:0], bin_q, 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

### rtl/sitoa_emit.sv
// ----------------------------------------------------------------------------
// sitoa_emit
// Character emitter: sign, then BCD digits MSD first, leading zeros dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sitoa_emit #(
	parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sitoa_pkg::emit_ctl_t        ctl,
	input  wire logic [sitoa_pkg::digit_count(VALUE_BITS)*4-1:0] digits,
	output logic                             busy,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [7:0]                       m_tdata,
	output logic                             m_tlast
);

	localparam int DIGITS = sitoa_pkg::digit_count(VALUE_BITS);
	localparam int BCD_W  = DIGITS * 4;
	localparam int CNT_W  = $clog2(DIGITS + 1);

	logic [BCD_W-1:0] dig_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             sign_q;
	logic             started_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic [3:0]       top_d;
	logic             can_push;
	logic             skip;
	logic             push;
	logic             is_final;

	always_comb begin
		top_d    = dig_q[BCD_W-1 -: 4];
		can_push = !valid_q || m_tready;
		is_final = (cnt_q == CNT_W'(1));
		// leading zero, but never the units digit
		skip     = !started_q && (top_d == 4'd0) && !is_final;
		push     = busy_q && can_push && (sign_q || !skip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			sign_q    <= 1'b0;
			started_q <= 1'b0;
			valid_q   <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (push)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;

			if (ctl.load) begin
				busy_q    <= 1'b1;
				sign_q    <= ctl.negative;
				started_q <= 1'b0;
				cnt_q     <= CNT_W'(DIGITS);
			end else if (busy_q) begin
				if (sign_q) begin
					if (can_push)
						sign_q <= 1'b0;
				end else if (skip) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else if (can_push) begin
					cnt_q     <= cnt_q - CNT_W'(1);
					started_q <= 1'b1;
					if (is_final)
						busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			dig_q <= digits;
		else if (busy_q && !sign_q && (skip || can_push))
			dig_q <= {dig_q[BCD_W-5:0], 4'd0};

		if (push) begin
			char_q <= sign_q ? sitoa_pkg::ASCII_MINUS
			                 : sitoa_pkg::ASCII_ZERO + {4'd0, top_d};
			last_q <= !sign_q && is_final;
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

### rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed two's complement integer to decimal ASCII text, one character/item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per integer; tdata holds the value in its low
//   VALUE_BITS bits (sign-extended from bit VALUE_BITS-1, upper bits ignored).
//   m_axis: one item per character, '-' first for negative values, then the
//   digits MSD first with no leading zeros; zero gives a single '0'.
//   tlast marks the last character of each value.
// Timing:
//   After an item is accepted the shift-add-3 converter runs one step per
//   bit of VALUE_BITS. The emitter then walks the DIGITS BCD digits one per
//   cycle (digit_count: 10 at 32 bits), a kept digit only when its output
//   register can take it, dropping leading zeros, and sends the sign and
//   each kept digit through that register. s_axis_tready is high only in idle.
// Reset: arst_n clears the sequencer and the output valid; no item pending.
// Stalls: m_axis_tready low holds the current character; the emitter waits.
//   The final character may still wait while the next integer is converted.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// slave side: integers in
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: [VALUE_BITS-1:0] value (signed), rest zero padding
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// master side: characters out
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// tdata: [7:0] character
	output logic [7:0]                           m_axis_tdata,
	output logic                                 m_axis_tlast
);

	localparam int DIGITS = sitoa_pkg::digit_count(VALUE_BITS);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic                  neg_q;

	logic                  in_fire;
	logic signed [VALUE_BITS-1:0] value;
	logic                  value_neg;
	logic [VALUE_BITS-1:0] mag;

	logic                  conv_done;
	logic [DIGITS*4-1:0]   bcd;
	logic                  emit_busy;
	sitoa_pkg::emit_ctl_t  ctl;

	always_comb begin
		in_fire   = s_axis_tvalid && s_axis_tready;
		value     = s_axis_tdata[VALUE_BITS-1:0];
		value_neg = value[VALUE_BITS-1];
		// the most negative value negates to 2^(VALUE_BITS-1), held unsigned
		mag       = value_neg ? (~value + VALUE_BITS'(1)) : value;

		ctl.load     = (state_q == ST_CONV) && conv_done;
		ctl.negative = neg_q;
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						neg_q   <= value_neg;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!emit_busy)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sitoa_dabble #(
		.VALUE_BITS(VALUE_BITS)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	sitoa_emit #(
		.VALUE_BITS(VALUE_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.digits   (bcd),
		.busy     (emit_busy),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

### rtl/sitoa_checker.sv
// ----------------------------------------------------------------------------
// sitoa_checker
// Port-level assertions for the integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sitoa_checker #(
	parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic [((VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [7:0]                      m_axis_tdata,
	input wire logic                            m_axis_tlast
);

	logic is_digit;
	logic is_minus;
	logic in_seen;

	assign is_digit = (m_axis_tdata >= sitoa_pkg::ASCII_ZERO)
	               && (m_axis_tdata <= sitoa_pkg::ASCII_ZERO + 8'd9);
	assign is_minus = (m_axis_tdata == sitoa_pkg::ASCII_MINUS);
	assign in_seen  = s_axis_tvalid && (s_axis_tdata[0] || !s_axis_tdata[0]);

	// a held character stays offered
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "character dropped")
	// one integer at a time
	`ASSERT_NEXT(a_one_item, in_seen && s_axis_tready, !s_axis_tready, "ready after accept")
	// only '-' or a decimal digit leaves
	`ASSERT_IMPL(a_charset, m_axis_tvalid, is_digit || is_minus, "bad character")
	// a sign is never the end of a run
	`ASSERT_IMPL(a_sign_not_last, m_axis_tvalid && is_minus, !m_axis_tlast, "sign marked last")

endmodule

bind signed_int_to_decimal_ascii sitoa_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_sitoa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
